[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge outside reset.
`define ZSTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ZSTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/zste_pkg.sv]
// ----------------------------------------------------------------------------
// zste_pkg
// Shared types, constants and helper functions of the sprite tile expander.
// ----------------------------------------------------------------------------
package zste_pkg;

  localparam int unsigned LutWords = 65536;
  localparam int unsigned LutAw    = $clog2(LutWords);

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 10;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SPRITES_DISABLED = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_FLIPPED   = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH     = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT    = 8'd3;

  localparam logic [9:0] ScreenWidthRst  = 10'd320;
  localparam logic [9:0] ScreenHeightRst = 10'd224;

  // Request types
  localparam logic REQ_LUT_WRITE = 1'b0;
  localparam logic REQ_SPRITE    = 1'b1;

  localparam int unsigned PosW    = 12;
  localparam int unsigned PosIntW = 13;

  typedef struct packed {
    logic        req_type;
    logic [15:0] lut_index;
    logic [15:0] lut_value;
    logic [15:0] y_word;
    logic [15:0] x_word;
    logic [15:0] attr_word;
    logic [16:0] tile_code;
  } zste_in_t;

  typedef struct packed {
    logic [15:0]            real_code;
    logic [7:0]             color_bits;
    logic                   flip_x;
    logic                   flip_y;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic [5:0]             scale_x;
    logic [5:0]             scale_y;
    logic [7:0]             prio_mask;
    logic                   last_tile;
  } zste_out_t;

  typedef struct packed {
    logic lut_write;
    logic capture;
    logic setup_center;
    logic setup_flip;
    logic issue;
  } zste_cmd_t;

  typedef struct packed {
    logic sprites_disabled;
    logic can_issue;
    logic last_tile;
  } zste_sts_t;

  function automatic logic [7:0] prio_to_mask(input logic [1:0] prio);
    logic [7:0] mask;
    case (prio)
      2'd0:    mask = 8'h00;
      2'd1:    mask = 8'hfc;
      default: mask = 8'hff;
    endcase
    return mask;
  endfunction

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [PosIntW-1:0] v);
    logic signed [PosW-1:0] r;
    if (v > $signed(13'sd2047)) begin
      r = 12'sd2047;
    end else if (v < $signed(-13'sd2048)) begin
      r = -12'sd2048;
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/zste_ctrl.sv]
// ----------------------------------------------------------------------------
// zste_ctrl
// Sequencer: accepts requests, steps through sprite setup, issues tiles.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zste_ctrl import zste_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_req_type_i,
  output logic      in_ready_o,
  input  zste_sts_t sts_i,
  output zste_cmd_t cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StCenter = 2'd1;
  localparam logic [1:0] StFlip   = 2'd2;
  localparam logic [1:0] StRun    = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_req_type_i == REQ_LUT_WRITE) begin
            cmd_o.lut_write = 1'b1;
          end else if (!sts_i.sprites_disabled) begin
            cmd_o.capture = 1'b1;
            state_d       = StCenter;
          end
        end
      end
      StCenter: begin
        cmd_o.setup_center = 1'b1;
        state_d            = StFlip;
      end
      StFlip: begin
        cmd_o.setup_flip = 1'b1;
        state_d          = StRun;
      end
      StRun: begin
        // issue one tile per cycle while the pipeline has room
        if (sts_i.can_issue) begin
          cmd_o.issue = 1'b1;
          if (sts_i.last_tile) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `ZSTE_ASSERT_NEXT(a_last_ends_run, cmd_o.issue && sts_i.last_tile, !cmd_o.issue, "tile issued after last tile")
  `ZSTE_ASSERT(a_no_issue_idle, in_ready_o |-> !cmd_o.issue, "tile issued while taking requests")
  `ZSTE_ASSERT(a_state_known, !$isunknown(state_q), "controller state unknown")

endmodule

[hw/rtl/zste_dp.sv]
// ----------------------------------------------------------------------------
// zste_dp
// Datapath: config registers, code table, sprite setup, tile pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zste_dp import zste_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  zste_in_t            in_data_i,
  input  zste_cmd_t           cmd_i,
  output zste_sts_t           sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output zste_out_t           out_data_o
);

  // Configuration
  logic       sprites_disabled_q, screen_flipped_q;
  logic [9:0] screen_width_q, screen_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sprites_disabled_q <= 1'b0;
      screen_flipped_q   <= 1'b0;
      screen_width_q     <= ScreenWidthRst;
      screen_height_q    <= ScreenHeightRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SPRITES_DISABLED: sprites_disabled_q <= cfg_data_i[0];
        CFG_SCREEN_FLIPPED:   screen_flipped_q   <= cfg_data_i[0];
        CFG_SCREEN_WIDTH:     screen_width_q     <= cfg_data_i[9:0];
        CFG_SCREEN_HEIGHT:    screen_height_q    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Sprite descriptor capture
  logic [15:0]      xw_q, yw_q, attr_q;
  logic [LutAw-1:0] code_q;

  // Setup results
  logic signed [PosIntW-1:0] pos_x_q, pos_y_q;
  logic [2:0]                nx_m1_q, ny_m1_q;
  logic [5:0]                sx_q, sy_q;
  logic                      fx_q, fy_q;
  logic [2:0]                col_q, row_q;

  // Center step
  logic [3:0]                shrink_x, shrink_y, nx, ny;
  logic [7:0]                cprod_x, cprod_y, cen_x, cen_y;
  logic signed [PosIntW-1:0] px_dec, py_dec;

  assign shrink_x = xw_q[15:12];
  assign shrink_y = yw_q[15:12];
  assign nx       = {1'b0, xw_q[11:9]} + 4'd1;
  assign ny       = {1'b0, yw_q[11:9]} + 4'd1;
  assign cprod_x  = {4'b0, nx} * {4'b0, shrink_x};
  assign cprod_y  = {4'b0, ny} * {4'b0, shrink_y};
  assign cen_x    = (cprod_x + 8'd2) >> 2;
  assign cen_y    = (cprod_y + 8'd2) >> 2;

  always_comb begin
    // X wraps negative from 0x180 up, Y bit 8 is a sign bit
    if (xw_q[8:0] >= 9'h180) begin
      px_dec = $signed({4'b0, xw_q[8:0]}) - $signed(13'sd512);
    end else begin
      px_dec = $signed({4'b0, xw_q[8:0]});
    end
    py_dec = $signed({5'b0, yw_q[7:0]}) - $signed({4'b0, yw_q[8], 8'b0});
  end

  // Flip step
  logic [3:0] nx_q4, ny_q4;
  logic [9:0] span_x, span_y;

  assign nx_q4  = {1'b0, nx_m1_q} + 4'd1;
  assign ny_q4  = {1'b0, ny_m1_q} + 4'd1;
  assign span_x = {6'b0, nx_q4} * {4'b0, sx_q};
  assign span_y = {6'b0, ny_q4} * {4'b0, sy_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      xw_q   <= in_data_i.x_word;
      yw_q   <= in_data_i.y_word;
      attr_q <= in_data_i.attr_word;
      code_q <= in_data_i.tile_code[LutAw-1:0];
    end else if (cmd_i.issue) begin
      code_q <= code_q + LutAw'(1);
    end
    if (cmd_i.setup_center) begin
      pos_x_q <= px_dec + $signed({5'b0, cen_x});
      pos_y_q <= py_dec + $signed({5'b0, cen_y});
      nx_m1_q <= xw_q[11:9];
      ny_m1_q <= yw_q[11:9];
      sx_q    <= 6'd32 - {2'b0, shrink_x};
      sy_q    <= 6'd32 - {2'b0, shrink_y};
      fx_q    <= attr_q[14];
      fy_q    <= attr_q[15];
    end else if (cmd_i.setup_flip && screen_flipped_q) begin
      pos_x_q <= $signed({3'b0, screen_width_q}) - pos_x_q - $signed({4'b0, span_x[9:1]});
      pos_y_q <= $signed({3'b0, screen_height_q}) - pos_y_q - $signed({4'b0, span_y[9:1]});
      fx_q    <= !fx_q;
      fy_q    <= !fy_q;
    end
  end

  // Row and column walk, rows outer
  logic last_tile;

  assign last_tile = (row_q == ny_m1_q) && (col_q == nx_m1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.setup_center) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.issue) begin
      if (col_q == nx_m1_q) begin
        col_q <= '0;
        row_q <= row_q + 3'd1;
      end else begin
        col_q <= col_q + 3'd1;
      end
    end
  end

  // Tile offset within the sprite
  logic [2:0]                dx, dy;
  logic [8:0]                oprod_x, oprod_y;
  logic signed [PosIntW-1:0] tx, ty;

  assign dx      = fx_q ? (nx_m1_q - col_q) : col_q;
  assign dy      = fy_q ? (ny_m1_q - row_q) : row_q;
  assign oprod_x = {6'b0, dx} * {3'b0, sx_q};
  assign oprod_y = {6'b0, dy} * {3'b0, sy_q};
  assign tx      = pos_x_q + $signed({5'b0, oprod_x[8:1]});
  assign ty      = pos_y_q + $signed({5'b0, oprod_y[8:1]});

  // Code table
  logic [15:0] mem [LutWords];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lut_write) begin
      mem[in_data_i.lut_index[LutAw-1:0]] <= in_data_i.lut_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rdata_q <= mem[code_q];
    end
  end

  // Tile pipeline: issue stage then output register
  zste_out_t s1_q, out_q, out_d;
  logic      s1_valid_q, out_valid_q, out_load;

  assign out_load = s1_valid_q && (!out_valid_q || out_ready_i);

  // merge the table word into the staged tile
  always_comb begin
    out_d           = s1_q;
    out_d.real_code = rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_q.real_code  <= '0;
      s1_q.color_bits <= attr_q[15:8];
      s1_q.flip_x     <= fx_q;
      s1_q.flip_y     <= fy_q;
      s1_q.pos_x      <= sat_pos(tx);
      s1_q.pos_y      <= sat_pos(ty);
      s1_q.scale_x    <= sx_q;
      s1_q.scale_y    <= sy_q;
      s1_q.prio_mask  <= prio_to_mask(attr_q[7:6]);
      s1_q.last_tile  <= last_tile;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.issue) begin
        s1_valid_q <= 1'b1;
      end else if (out_load) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.sprites_disabled = sprites_disabled_q;
  assign sts_o.can_issue        = !s1_valid_q || out_load;
  assign sts_o.last_tile        = last_tile;
  assign out_valid_o            = out_valid_q;
  assign out_data_o             = out_q;

  `ZSTE_ASSERT_NEXT(a_s1_hold, s1_valid_q && !out_load, s1_valid_q && $stable(s1_q), "issue stage lost a tile")
  `ZSTE_ASSERT(a_walk_bounds, cmd_i.issue |-> ((row_q <= ny_m1_q) && (col_q <= nx_m1_q)), "tile walk out of bounds")
  `ZSTE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "output changed while stalled")

endmodule

[hw/rtl/zoomed_sprite_tile_expander_top.sv]
// An accepted descriptor steps through center and flip setup before its first tile issues.
// Throughput: one tile per cycle while out_ready_i does not stall the output, from a two-stage
//   issue/output pipeline; a sprite has 1 to 64 tiles.
// The code table is a single-port-write, single-port-read memory read once per tile.
// Reset clears control state, restores config defaults; table stays undefined until written.
// ----------------------------------------------------------------------------
// zoomed_sprite_tile_expander_top
// Expands zoomed sprite descriptors into tile records via a code lookup table.
// ----------------------------------------------------------------------------
module zoomed_sprite_tile_expander_top import zste_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  zste_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output zste_out_t           out_data_o
);

  zste_cmd_t cmd;
  zste_sts_t sts;

  assign cfg_ready_o = 1'b1;

  zste_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_data_i.req_type),
    .in_ready_o    (in_ready_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  zste_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
